>>> sv/bts_pkg.sv
package bts_pkg;

  // Fixed field widths of the item and result channels.
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 1;
  localparam int SIZE_W          = 9;
  localparam int POS_W           = COORD_W + SIZE_W;
  localparam int CHAN_W          = 8;
  localparam int NUM_CH          = 3;
  localparam int PROD_W          = CHAN_W + COORD_W;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = SIZE_W;

  localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(1) << COORD_FRAC_BITS;
  localparam logic [POS_W-1:0]   COORD_HALF = POS_W'(1) << (COORD_FRAC_BITS - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;
  localparam logic MODE_GRAY  = 1'b0;

  localparam logic [SIZE_W-1:0] RESET_SIZE = 9'd256;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COLOR = 2'd1,
    STATUS_OUTSIDE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_AXMUL,
    ST_AXCLAMP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RDLAST,
    ST_HMUL,
    ST_HSUM,
    ST_VMUL,
    ST_DONE
  } state_e;

  // One texel, red in the low byte.
  typedef logic [NUM_CH-1:0][CHAN_W-1:0] texel_t;

  typedef struct packed {
    logic mul_en;
    logic clamp_en;
  } axis_ctl_t;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         texel_x;
    logic [7:0]         texel_y;
    logic               write_is_gray;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
  } item_t;

endpackage

>>> sv/bts_if.sv
interface bts_item_if;
  import bts_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         texel_x;
  logic [7:0]         texel_y;
  logic               write_is_gray;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;
  logic [COORD_W-1:0] coord_u;
  logic [COORD_W-1:0] coord_v;

  modport source (
    output valid, opcode, texel_x, texel_y, write_is_gray, red_in, green_in, blue_in,
    output coord_u, coord_v,
    input  ready
  );
  modport sink (
    input  valid, opcode, texel_x, texel_y, write_is_gray, red_in, green_in, blue_in,
    input  coord_u, coord_v,
    output ready
  );
endinterface

interface bts_result_if;
  import bts_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic [1:0]        status;

  modport source (output valid, red_out, green_out, blue_out, status, input ready);
  modport sink (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

interface bts_cfg_if;
  import bts_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/bts_texmem.sv
module bts_texmem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  bts_pkg::texel_t wdata_i,
  output bts_pkg::texel_t rdata_o
);
  import bts_pkg::*;

  texel_t mem [DEPTH];
  texel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bts_axis.sv
module bts_axis (
  input  logic                                clk_i,
  input  bts_pkg::axis_ctl_t                  ctl_i,
  input  logic [bts_pkg::COORD_W-1:0]         coord_i,
  input  logic [bts_pkg::SIZE_W-1:0]          size_i,
  output logic [bts_pkg::SIZE_W-1:0]          lo_o,
  output logic [bts_pkg::SIZE_W-1:0]          hi_o,
  output logic [bts_pkg::COORD_FRAC_BITS-1:0] frac_o
);
  import bts_pkg::*;

  logic [COORD_W-1:0]         coord_sat;
  logic [POS_W-1:0]           pos_d, pos_q;
  logic [SIZE_W:0]            rounded;
  logic [SIZE_W:0]            lo_raw;
  logic [SIZE_W-1:0]          size_m1;
  logic [SIZE_W-1:0]          lo_d, hi_d;
  logic [SIZE_W-1:0]          lo_q, hi_q;
  logic [COORD_FRAC_BITS-1:0] frac_q;

  // Coordinates above one saturate, then scale by the size with half added.
  assign coord_sat = (coord_i > COORD_ONE) ? COORD_ONE : coord_i;
  assign pos_d     = POS_W'(coord_sat) * POS_W'(size_i) + COORD_HALF;

  // The rounded index is the texel to the right of the sample; clamp both
  // neighbors to the last texel.
  always_comb begin
    rounded = pos_q[POS_W-1 -: SIZE_W+1];
    size_m1 = size_i - SIZE_W'(1);
    lo_raw  = (rounded == '0) ? '0 : rounded - (SIZE_W+1)'(1);
    lo_d    = (lo_raw > {1'b0, size_m1}) ? size_m1 : lo_raw[SIZE_W-1:0];
    hi_d    = (rounded > {1'b0, size_m1}) ? size_m1 : rounded[SIZE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      pos_q <= pos_d;
    end
    if (ctl_i.clamp_en) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      frac_q <= pos_q[COORD_FRAC_BITS-1:0];
    end
  end

  assign lo_o   = lo_q;
  assign hi_o   = hi_q;
  assign frac_o = frac_q;

endmodule

>>> sv/bts_lerp.sv
module bts_lerp (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [bts_pkg::CHAN_W-1:0]          a_i,
  input  logic [bts_pkg::CHAN_W-1:0]          b_i,
  input  logic [bts_pkg::COORD_FRAC_BITS-1:0] t_i,
  output logic [bts_pkg::CHAN_W-1:0]          y_o
);
  import bts_pkg::*;

  logic [COORD_W-1:0] t_inv;
  logic [PROD_W-1:0]  pa_q, pb_q;
  logic [PROD_W-1:0]  sum;

  assign t_inv = COORD_ONE - {1'b0, t_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= PROD_W'(a_i) * PROD_W'(t_inv);
      pb_q <= PROD_W'(b_i) * PROD_W'(t_i);
    end
  end

  // The weighted sum never exceeds 255 in the integer part; truncate.
  assign sum = pa_q + pb_q;
  assign y_o = sum[COORD_FRAC_BITS +: CHAN_W];

endmodule

>>> sv/bilinear_texture_sampler_core.sv
// Write item: the texel is written in state WRITE, then the result is loaded in DONE.
// Sample item: the result is loaded in DONE after the axis, read and filter states; the
// single texel memory port serves the four neighbor reads in the successive states RD0 to RD3.
// The block works on one item at a time; a waiting result stalls DONE but not acceptance in IDLE.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, drops any pending result
// and loads width 256, height 256 and RGB mode. Texel memory contents are not cleared.
module bilinear_texture_sampler_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bts_cfg_if.sink      cfg_i,
  bts_item_if.sink     item_i,
  bts_result_if.source result_o
);
  import bts_pkg::*;

  localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NumLanes = 2 * NUM_CH;

  // Configuration registers, never stalling; the user must write only while idle (unchecked).
  logic [SIZE_W-1:0] width_q, height_q;
  logic              mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_SIZE;
      height_q <= RESET_SIZE;
      mode_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        CFG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        CFG_COLOR_MODE:   mode_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Effective image size: the register value clamped to one through the maximum.
  logic [SIZE_W-1:0] eff_w, eff_h;

  always_comb begin
    if (width_q == '0) begin
      eff_w = SIZE_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = SIZE_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = SIZE_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = SIZE_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  // Texels live row by row with a stride of the maximum width.
  function automatic logic [AddrW-1:0] texel_addr(logic [SIZE_W-1:0] col,
                                                  logic [SIZE_W-1:0] row);
    return AddrW'(32'(row) * MAX_WIDTH + 32'(col));
  endfunction

  // Sequencer state and the accepted item.
  state_e state_q, state_d;
  item_t  item_q;
  logic   item_acc;
  logic   slot_free;
  logic   load_res;
  logic   res_valid_q;

  assign item_acc  = item_i.valid && item_i.ready;
  assign slot_free = !res_valid_q || result_o.ready;

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      item_q.opcode        <= item_i.opcode;
      item_q.texel_x       <= item_i.texel_x;
      item_q.texel_y       <= item_i.texel_y;
      item_q.write_is_gray <= item_i.write_is_gray;
      item_q.red_in        <= item_i.red_in;
      item_q.green_in      <= item_i.green_in;
      item_q.blue_in       <= item_i.blue_in;
      item_q.coord_u       <= item_i.coord_u;
      item_q.coord_v       <= item_i.coord_v;
    end
  end

  // Write checks: the image bounds come before the color type check.
  status_e wr_status;
  texel_t  wr_texel;

  always_comb begin
    if ({1'b0, item_q.texel_x} >= eff_w || {1'b0, item_q.texel_y} >= eff_h) begin
      wr_status = STATUS_OUTSIDE;
    end else if (mode_q == MODE_GRAY && !item_q.write_is_gray) begin
      wr_status = STATUS_BAD_COLOR;
    end else begin
      wr_status = STATUS_OK;
    end
    wr_texel[0] = item_q.red_in;
    wr_texel[1] = item_q.write_is_gray ? item_q.red_in : item_q.green_in;
    wr_texel[2] = item_q.write_is_gray ? item_q.red_in : item_q.blue_in;
  end

  // Per-axis neighbor and weight units.
  axis_ctl_t                  axis_ctl;
  logic [SIZE_W-1:0]          x0, x1, y0, y1;
  logic [COORD_FRAC_BITS-1:0] dx, dy;

  bts_axis u_axis_x (
    .clk_i   (clk_i),
    .ctl_i   (axis_ctl),
    .coord_i (item_q.coord_u),
    .size_i  (eff_w),
    .lo_o    (x0),
    .hi_o    (x1),
    .frac_o  (dx)
  );

  bts_axis u_axis_y (
    .clk_i   (clk_i),
    .ctl_i   (axis_ctl),
    .coord_i (item_q.coord_v),
    .size_i  (eff_h),
    .lo_o    (y0),
    .hi_o    (y1),
    .frac_o  (dy)
  );

  // Texel memory, one port shared by writes and the four sample reads.
  logic             mem_en, mem_we;
  logic [AddrW-1:0] mem_addr;
  texel_t           mem_rdata;

  bts_texmem #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_texmem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wr_texel),
    .rdata_o (mem_rdata)
  );

  // Read data is registered in the memory and is captured in the state after each read is issued.
  texel_t tex00_q, tex10_q, tex01_q, tex11_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_RD1:    tex00_q <= mem_rdata;
      ST_RD2:    tex10_q <= mem_rdata;
      ST_RD3:    tex01_q <= mem_rdata;
      ST_RDLAST: tex11_q <= mem_rdata;
      default: ;
    endcase
  end

  // Interpolation lanes. Lanes below NUM_CH filter the top row per channel and
  // later do the vertical pass; the upper lanes filter the bottom row.
  logic [CHAN_W-1:0]          lane_a [NumLanes];
  logic [CHAN_W-1:0]          lane_b [NumLanes];
  logic [COORD_FRAC_BITS-1:0] lane_t [NumLanes];
  logic [CHAN_W-1:0]          lane_y [NumLanes];
  logic                       lane_en_top, lane_en_bot;
  texel_t                     top_q, bot_q;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (state_q == ST_VMUL) begin
        lane_a[ch] = top_q[ch];
        lane_b[ch] = bot_q[ch];
        lane_t[ch] = dy;
      end else begin
        lane_a[ch] = tex00_q[ch];
        lane_b[ch] = tex10_q[ch];
        lane_t[ch] = dx;
      end
      lane_a[ch+NUM_CH] = tex01_q[ch];
      lane_b[ch+NUM_CH] = tex11_q[ch];
      lane_t[ch+NUM_CH] = dx;
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    bts_lerp u_lerp (
      .clk_i (clk_i),
      .en_i  ((l < NUM_CH) ? lane_en_top : lane_en_bot),
      .a_i   (lane_a[l]),
      .b_i   (lane_b[l]),
      .t_i   (lane_t[l]),
      .y_o   (lane_y[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HSUM) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        top_q[ch] <= lane_y[ch];
        bot_q[ch] <= lane_y[ch+NUM_CH];
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          state_d = (item_i.opcode == OP_SAMPLE) ? ST_AXMUL : ST_WRITE;
        end
      end
      ST_WRITE:   state_d = ST_DONE;
      ST_AXMUL:   state_d = ST_AXCLAMP;
      ST_AXCLAMP: state_d = ST_RD0;
      ST_RD0:     state_d = ST_RD1;
      ST_RD1:     state_d = ST_RD2;
      ST_RD2:     state_d = ST_RD3;
      ST_RD3:     state_d = ST_RDLAST;
      ST_RDLAST:  state_d = ST_HMUL;
      ST_HMUL:    state_d = ST_HSUM;
      ST_HSUM:    state_d = ST_VMUL;
      ST_VMUL:    state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer outputs.
  always_comb begin
    item_i.ready      = 1'b0;
    mem_en            = 1'b0;
    mem_we            = 1'b0;
    mem_addr          = texel_addr(x0, y0);
    axis_ctl.mul_en   = 1'b0;
    axis_ctl.clamp_en = 1'b0;
    lane_en_top       = 1'b0;
    lane_en_bot       = 1'b0;
    load_res          = 1'b0;
    case (state_q)
      ST_IDLE:    item_i.ready = 1'b1;
      ST_WRITE: begin
        mem_en   = (wr_status == STATUS_OK);
        mem_we   = (wr_status == STATUS_OK);
        mem_addr = texel_addr({1'b0, item_q.texel_x}, {1'b0, item_q.texel_y});
      end
      ST_AXMUL:   axis_ctl.mul_en = 1'b1;
      ST_AXCLAMP: axis_ctl.clamp_en = 1'b1;
      ST_RD0: begin
        mem_en   = 1'b1;
        mem_addr = texel_addr(x0, y0);
      end
      ST_RD1: begin
        mem_en   = 1'b1;
        mem_addr = texel_addr(x1, y0);
      end
      ST_RD2: begin
        mem_en   = 1'b1;
        mem_addr = texel_addr(x0, y1);
      end
      ST_RD3: begin
        mem_en   = 1'b1;
        mem_addr = texel_addr(x1, y1);
      end
      ST_HMUL: begin
        lane_en_top = 1'b1;
        lane_en_bot = 1'b1;
      end
      ST_VMUL:    lane_en_top = 1'b1;
      ST_DONE:    load_res = slot_free;
      default: ;
    endcase
  end

  // Result register: holds a finished item until the sink takes it.
  texel_t  res_d, res_q;
  status_e res_status_d, res_status_q;

  always_comb begin
    if (item_q.opcode == OP_WRITE) begin
      res_d        = '0;
      res_status_d = wr_status;
    end else begin
      res_d[0]     = lane_y[0];
      res_d[1]     = (mode_q == MODE_GRAY) ? lane_y[0] : lane_y[1];
      res_d[2]     = (mode_q == MODE_GRAY) ? lane_y[0] : lane_y[2];
      res_status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q        <= res_d;
      res_status_q <= res_status_d;
    end
  end

  assign result_o.valid     = res_valid_q;
  assign result_o.red_out   = res_q[0];
  assign result_o.green_out = res_q[1];
  assign result_o.blue_out  = res_q[2];
  assign result_o.status    = res_status_q;

endmodule
